/* design/ial_pkg.sv */
// ----------------------------------------------------------------------------
// ial_pkg: shared types and constants of the indexed array list
// Request codes, status codes, field widths and the command that the
// request decoder hands to the storage cells.
// ----------------------------------------------------------------------------
package ial_pkg;

  // fixed field widths of the stream items
  localparam int unsigned OpW       = 2;
  localparam int unsigned InIdxW    = 4;
  localparam int unsigned DataW     = 32;
  localparam int unsigned StatusW   = 2;
  localparam int unsigned CountOutW = 5;

  // packed stream widths, padded to whole bytes
  localparam int unsigned InFieldsW  = OpW + InIdxW + DataW;
  localparam int unsigned InTdataW   = ((InFieldsW + 7) / 8) * 8;
  localparam int unsigned OutFieldsW = DataW + StatusW + CountOutW;
  localparam int unsigned OutTdataW  = ((OutFieldsW + 7) / 8) * 8;

  // default list depth
  localparam int unsigned ListDepthDef = 16;

  // request codes
  typedef enum logic [OpW-1:0] {
    OP_APPEND = 2'd0,
    OP_INSERT = 2'd1,
    OP_DELETE = 2'd2,
    OP_READ   = 2'd3
  } op_e;

  // status codes
  typedef enum logic [StatusW-1:0] {
    ST_DONE  = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // update command for the storage cells
  typedef struct packed {
    logic apply;
    op_e  op;
  } cell_cmd_t;

endpackage

/* design/ial_cells.sv */
// ----------------------------------------------------------------------------
// ial_cells: storage cells of the indexed array list
// Each cell holds, loads the new word, takes its lower neighbour (insert)
// or its upper neighbour (delete); one word is read out by index.
// ----------------------------------------------------------------------------
module ial_cells
  import ial_pkg::*;
#(
  parameter int unsigned ListDepth = ListDepthDef,
  parameter int unsigned CmpW      = 5
) (
  input  logic                    clk_i,
  input  cell_cmd_t               cmd_i,
  input  logic [CmpW-1:0]         idx_i,
  input  logic [CmpW-1:0]         count_i,
  input  logic signed [DataW-1:0] value_i,
  output logic signed [DataW-1:0] rd_word_o
);

  logic signed [DataW-1:0] cell_q [ListDepth];

  // per-cell update: hold, load, shift up or shift down
  for (genvar k = 0; k < ListDepth; k++) begin : g_cell
    localparam logic [CmpW-1:0] Pos = CmpW'(k);
    logic signed [DataW-1:0] lower_w;
    logic signed [DataW-1:0] upper_w;

    if (k == 0) begin : g_bot
      assign lower_w = cell_q[k];
    end else begin : g_low
      assign lower_w = cell_q[k-1];
    end

    if (k == ListDepth - 1) begin : g_top
      assign upper_w = cell_q[k];
    end else begin : g_up
      assign upper_w = cell_q[k+1];
    end

    always_ff @(posedge clk_i) begin
      if (cmd_i.apply) begin
        case (cmd_i.op)
          OP_APPEND: begin
            if (Pos == count_i) cell_q[k] <= value_i;
          end
          OP_INSERT: begin
            if (Pos == idx_i) cell_q[k] <= value_i;
            else if (Pos > idx_i) cell_q[k] <= lower_w;
          end
          OP_DELETE: begin
            if (Pos >= idx_i) cell_q[k] <= upper_w;
          end
          default: begin
          end
        endcase
      end
    end
  end

  // read port: one-hot select by index
  always_comb begin
    rd_word_o = '0;
    for (int unsigned k = 0; k < ListDepth; k++) begin
      if (CmpW'(k) == idx_i) rd_word_o = cell_q[k];
    end
  end

endmodule

/* design/ial_ctrl.sv */
// ----------------------------------------------------------------------------
// ial_ctrl: request decoder and word count of the indexed array list
// Checks a request against the count, sets the status, keeps the count
// and issues the update command to the cells.
// ----------------------------------------------------------------------------
module ial_ctrl
  import ial_pkg::*;
#(
  parameter int unsigned ListDepth = ListDepthDef,
  parameter int unsigned CntW      = 5,
  parameter int unsigned CmpW      = 5
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    fire_i,
  input  op_e                     op_i,
  input  logic [InIdxW-1:0]       idx_i,
  input  logic signed [DataW-1:0] rd_word_i,
  output cell_cmd_t               cmd_o,
  output logic [CmpW-1:0]         idx_cmp_o,
  output logic [CmpW-1:0]         count_cmp_o,
  output status_e                 status_o,
  output logic signed [DataW-1:0] read_value_o,
  output logic [CountOutW-1:0]    count_o
);

  localparam logic [CntW-1:0] DepthCnt = CntW'(ListDepth);
  localparam logic [CntW-1:0] OneCnt   = CntW'(1);

  logic [CntW-1:0] count_q;
  logic [CntW-1:0] count_d;
  logic            full;
  logic            in_range;

  assign idx_cmp_o   = CmpW'(idx_i);
  assign count_cmp_o = CmpW'(count_q);
  assign full        = (count_q >= DepthCnt);
  assign in_range    = (idx_cmp_o < count_cmp_o);

  // status of the request
  always_comb begin
    status_o = ST_DONE;
    case (op_i)
      OP_APPEND: if (full) status_o = ST_FULL;
      OP_INSERT: begin
        if (full) status_o = ST_FULL;
        else if (!in_range) status_o = ST_RANGE;
      end
      OP_DELETE, OP_READ: if (!in_range) status_o = ST_RANGE;
      default: status_o = ST_DONE;
    endcase
  end

  // cell command and next count
  always_comb begin
    cmd_o.op    = op_i;
    cmd_o.apply = fire_i && (status_o == ST_DONE) && (op_i != OP_READ);
    count_d     = count_q;
    if (cmd_o.apply) begin
      case (op_i)
        OP_APPEND, OP_INSERT: count_d = count_q + OneCnt;
        OP_DELETE:            count_d = count_q - OneCnt;
        default:              count_d = count_q;
      endcase
    end
  end

  // result fields
  assign read_value_o = ((op_i == OP_READ) && (status_o == ST_DONE)) ? rd_word_i : '0;
  assign count_o      = CountOutW'(count_d);

  // word count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

endmodule

/* design/indexed_array_list.sv */
// ----------------------------------------------------------------------------
// indexed_array_list: ordered list of signed 32-bit words
// Append, insert, delete and read by index with one status result each.
// ----------------------------------------------------------------------------
// The block takes one request per clock while its result register is free or
// being emptied, and returns one result per request: a request is captured in
// the input register, checked and applied from there, and its result waits in
// the result register until taken. Every storage cell loads, holds or takes
// a neighbour in parallel, so insert and delete take no longer than append
// and read. The list is empty after reset; status 1 means the index is
// not below the count, status 2 that the list is full. element_count shows the
// low five bits of the count after the request.
module indexed_array_list
  import ial_pkg::*;
#(
  parameter int unsigned ListDepth = ListDepthDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // op [1:0], element_index [5:2], element_value [37:6], zero pad above
  input  logic [InTdataW-1:0]  s_axis_tdata,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // read_value [31:0], status [33:32], element_count [38:34], zero pad above
  output logic [OutTdataW-1:0] m_axis_tdata,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready
);

  localparam int unsigned CntW = $clog2(ListDepth + 1);
  localparam int unsigned CmpW = (CntW > InIdxW) ? CntW : InIdxW;

  logic                    in_valid_q;
  op_e                     in_op_q;
  logic [InIdxW-1:0]       in_idx_q;
  logic signed [DataW-1:0] in_val_q;
  logic                    out_valid_q;
  logic [OutTdataW-1:0]    out_data_q;
  logic                    fire;
  logic                    in_take;

  cell_cmd_t               cmd;
  logic [CmpW-1:0]         idx_cmp;
  logic [CmpW-1:0]         count_cmp;
  status_e                 status;
  logic signed [DataW-1:0] rd_word;
  logic signed [DataW-1:0] read_value;
  logic [CountOutW-1:0]    count_out;

  // handshake: process when the result register is free or being emptied
  assign fire          = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || fire;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_op_q  <= op_e'(s_axis_tdata[OpW-1:0]);
      in_idx_q <= s_axis_tdata[OpW +: InIdxW];
      in_val_q <= s_axis_tdata[OpW+InIdxW +: DataW];
    end
  end

  // request decoder and count
  ial_ctrl #(
    .ListDepth (ListDepth),
    .CntW      (CntW),
    .CmpW      (CmpW)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fire_i       (fire),
    .op_i         (in_op_q),
    .idx_i        (in_idx_q),
    .rd_word_i    (rd_word),
    .cmd_o        (cmd),
    .idx_cmp_o    (idx_cmp),
    .count_cmp_o  (count_cmp),
    .status_o     (status),
    .read_value_o (read_value),
    .count_o      (count_out)
  );

  // storage cells
  ial_cells #(
    .ListDepth (ListDepth),
    .CmpW      (CmpW)
  ) u_cells (
    .clk_i     (clk_i),
    .cmd_i     (cmd),
    .idx_i     (idx_cmp),
    .count_i   (count_cmp),
    .value_i   (in_val_q),
    .rd_word_o (rd_word)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_data_q <= OutTdataW'({count_out, status, read_value});
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

/* bench/indexed_array_list_tb.sv */
// ----------------------------------------------------------------------------
// indexed_array_list_tb: self-checking bench for the indexed array list
// Drives append, insert, delete and read requests on the input stream and
// keeps its own copy of the list to work out each result. Every result on the
// output stream is compared field by field with the oldest outstanding one.
// Both stream sides idle at random, the receiver holds off for a long stretch
// once, and the sender pauses once until the list has answered everything.
// ----------------------------------------------------------------------------
module indexed_array_list_tb;
  import ial_pkg::*;

  localparam int unsigned Depth      = ListDepthDef;
  localparam int unsigned MaxReports = 10;

  // one result of the list, as the predictor works it out
  typedef struct packed {
    logic [DataW-1:0]     read_value;
    status_e              status;
    logic [CountOutW-1:0] element_count;
  } list_result_t;

  logic                 clk_i = 1'b0;
  logic                 rst_n = 1'b0;
  logic [InTdataW-1:0]  req_tdata = '0;
  logic                 req_tvalid = 1'b0;
  logic                 req_tready;
  logic [OutTdataW-1:0] rsp_tdata;
  logic                 rsp_tvalid;
  logic                 rsp_tready = 1'b0;

  // predictor state: the words held and their number
  logic [DataW-1:0] list_words [Depth];
  int unsigned      word_count = 0;

  list_result_t expected_results [$];
  int unsigned  mismatch_count = 0;
  bit           idle_en = 1'b1;
  int unsigned  rx_hold_req = 0;

  indexed_array_list u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_n),
    .s_axis_tdata  (req_tdata),
    .s_axis_tvalid (req_tvalid),
    .s_axis_tready (req_tready),
    .m_axis_tdata  (rsp_tdata),
    .m_axis_tvalid (rsp_tvalid),
    .m_axis_tready (rsp_tready)
  );

  // clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // gap length: mostly short, now and then long
  function automatic int unsigned pick_gap();
    if ($urandom_range(99) < 80) begin
      return $urandom_range(3, 1);
    end
    return $urandom_range(40, 10);
  endfunction

  // apply one request to the list copy and return its result
  function automatic list_result_t apply_request(op_e op, logic [InIdxW-1:0] idx,
                                                 logic [DataW-1:0] val);
    list_result_t res;
    res.read_value = '0;
    res.status     = ST_DONE;
    case (op)
      OP_APPEND: begin
        if (word_count >= Depth) begin
          res.status = ST_FULL;
        end else begin
          list_words[word_count] = val;
          word_count++;
        end
      end
      OP_INSERT: begin
        if (word_count >= Depth) begin
          res.status = ST_FULL;
        end else if (idx >= word_count) begin
          res.status = ST_RANGE;
        end else begin
          for (int k = word_count; k > idx; k--) begin
            list_words[k] = list_words[k-1];
          end
          list_words[idx] = val;
          word_count++;
        end
      end
      OP_DELETE: begin
        if (idx >= word_count) begin
          res.status = ST_RANGE;
        end else begin
          for (int k = idx; k + 1 < word_count; k++) begin
            list_words[k] = list_words[k+1];
          end
          word_count--;
        end
      end
      default: begin
        if (idx >= word_count) begin
          res.status = ST_RANGE;
        end else begin
          res.read_value = list_words[idx];
        end
      end
    endcase
    res.element_count = word_count[CountOutW-1:0];
    return res;
  endfunction

  // offer one request and wait for its transaction; valid stays high after
  task automatic send_request(op_e op, logic [InIdxW-1:0] idx, logic [DataW-1:0] val);
    int unsigned gap;
    bit          taken;
    gap = 0;
    if (idle_en && $urandom_range(1) == 0) begin
      gap = pick_gap();
    end
    if (gap > 0) begin
      req_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_tdata  <= {{(InTdataW - InFieldsW){1'b0}}, val, idx, op};
    req_tvalid <= 1'b1;
    // inputs only move at rising edges, so the falling edge shows what the next
    // rising edge will see
    do begin
      @(negedge clk_i);
      taken = req_tready;
      @(posedge clk_i);
    end while (!taken);
    expected_results.push_back(apply_request(op, idx, val));
  endtask

  // drop valid and wait until a rising edge has seen it low before anything is driven again
  task automatic release_bus();
    req_tvalid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic wait_drained();
    release_bus();
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  // receiver ready, with random stalls and the long hold-off on request
  initial begin : rx_ready_gen
    int unsigned stall_left;
    stall_left = 0;
    @(posedge rst_n);
    forever begin
      @(posedge clk_i);
      if (rx_hold_req != 0) begin
        stall_left  = rx_hold_req;
        rx_hold_req = 0;
      end else if (stall_left > 0) begin
        stall_left--;
      end else if (idle_en && $urandom_range(3) == 0) begin
        stall_left = pick_gap();
      end
      rsp_tready <= (stall_left == 0);
    end
  end

  // result checker, sampled on the falling edge ahead of the transaction
  always @(negedge clk_i) begin : result_check
    list_result_t want;
    list_result_t got;
    if (rst_n && rsp_tvalid && rsp_tready) begin
      got.read_value    = rsp_tdata[DataW-1:0];
      got.status        = status_e'(rsp_tdata[DataW +: StatusW]);
      got.element_count = rsp_tdata[DataW + StatusW +: CountOutW];
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MaxReports) begin
          $display("unexpected result: read_value %h status %0d count %0d",
                   got.read_value, got.status, got.element_count);
        end
      end else begin
        want = expected_results.pop_front();
        if (got.read_value !== want.read_value || got.status !== want.status ||
            got.element_count !== want.element_count) begin
          mismatch_count++;
          if (mismatch_count <= MaxReports) begin
            $display("mismatch: expected value %h status %0d count %0d, got %h %0d %0d",
                     want.read_value, want.status, want.element_count,
                     got.read_value, got.status, got.element_count);
          end
        end
      end
    end
  end

  // edge cases on a short list: empty list, extreme words, ends of the list
  task automatic test_directed();
    send_request(OP_INSERT, 4'd0, 32'h0000_0011);
    send_request(OP_DELETE, 4'd0, 32'h0);
    send_request(OP_READ, 4'd15, 32'h0);
    send_request(OP_APPEND, 4'd15, 32'h7FFF_FFFF);
    send_request(OP_APPEND, 4'd0, 32'h8000_0000);
    send_request(OP_APPEND, 4'd9, 32'h0000_0000);
    send_request(OP_APPEND, 4'd3, 32'hFFFF_FFFF);
    send_request(OP_INSERT, 4'd0, 32'h0000_0001);
    send_request(OP_INSERT, 4'd4, 32'h5A5A_A5A5);
    // inserting at the count is out of range
    send_request(OP_INSERT, 4'd6, 32'h1234_5678);
    send_request(OP_READ, 4'd0, 32'hFFFF_FFFF);
    send_request(OP_READ, 4'd5, 32'h0);
    send_request(OP_READ, 4'd6, 32'h0);
    send_request(OP_DELETE, 4'd5, 32'h0);
    send_request(OP_DELETE, 4'd0, 32'h0);
    send_request(OP_DELETE, 4'd15, 32'hFFFF_FFFF);
    send_request(OP_READ, 4'd2, 32'h0);
    release_bus();
  endtask

  // fill to the depth, push against the full list, then empty it again
  task automatic test_full_list();
    while (word_count < Depth) begin
      send_request(OP_APPEND, 4'($urandom), $urandom);
    end
    send_request(OP_APPEND, 4'd0, 32'hDEAD_BEEF);
    send_request(OP_INSERT, 4'd0, 32'h7FFF_FFFF);
    send_request(OP_INSERT, 4'd15, 32'h8000_0000);
    send_request(OP_READ, 4'd15, 32'h0);
    send_request(OP_DELETE, 4'd15, 32'h0);
    send_request(OP_APPEND, 4'd7, 32'h8000_0000);
    send_request(OP_READ, 4'd0, 32'h0);
    while (word_count > 0) begin
      send_request(OP_DELETE, 4'd0, 32'h0);
    end
    send_request(OP_READ, 4'd0, 32'h0);
    release_bus();
  endtask

  // one random request; bias 0 even mix, 1 growing, 2 shrinking
  task automatic send_random(int bias);
    int unsigned r;
    op_e         op;
    logic [InIdxW-1:0] idx;
    logic [DataW-1:0]  val;
    r = $urandom_range(99);
    case (bias)
      1:       op = (r < 35) ? OP_APPEND : (r < 70) ? OP_INSERT : (r < 80) ? OP_DELETE : OP_READ;
      2:       op = (r < 10) ? OP_APPEND : (r < 20) ? OP_INSERT : (r < 70) ? OP_DELETE : OP_READ;
      default: op = op_e'(r % 4);
    endcase
    if (word_count > 0 && $urandom_range(99) < 80) begin
      idx = InIdxW'($urandom_range(word_count - 1));
    end else begin
      idx = InIdxW'($urandom);
    end
    case ($urandom_range(19))
      0:       val = 32'h7FFF_FFFF;
      1:       val = 32'h8000_0000;
      2:       val = 32'hFFFF_FFFF;
      3:       val = 32'h0000_0000;
      default: val = $urandom;
    endcase
    send_request(op, idx, val);
  endtask

  task automatic test_random(int unsigned n, int bias, bit with_idle);
    idle_en = with_idle;
    repeat (n) send_random(bias);
    release_bus();
    idle_en = 1'b1;
  endtask

  // receiver holds off while requests keep coming, so the input stalls
  task automatic test_backpressure();
    idle_en     = 1'b0;
    rx_hold_req = 300;
    repeat (24) send_random(0);
    release_bus();
    idle_en = 1'b1;
  endtask

  // sender stops until every result is back, then carries on
  task automatic test_pause_drain();
    repeat (10) send_random(1);
    wait_drained();
    repeat (10) send_random(2);
    release_bus();
  endtask

  // reset and test sequence
  initial begin
    repeat (3) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_full_list();
    test_backpressure();
    test_random(100, 1, 1'b1);
    test_random(100, 0, 1'b0);
    test_pause_drain();
    test_random(100, 2, 1'b1);
    test_random(100, 1, 1'b1);
    test_random(100, 0, 1'b1);
    wait_drained();
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
